// ----- design/vrp_pkg.sv -----
// vrp_pkg: shared types, codes and helpers for the VMM3 readout parser.
// No dependencies; used by every module in design/ except vrp_ram.
`timescale 1ns / 1ps
package vrp_pkg;

	localparam int VMMS_PER_FEC_DEF = 32;
	localparam int FEC_COUNT_DEF    = 16;
	localparam int MAX_HITS_DEF     = 512;
	localparam int HEADER_BYTES     = 16;
	localparam int WORD_BYTES       = 6;
	localparam int TADDR_W          = 9;   // widest table address (16 x 32)
	localparam int QUEUE_DEPTH      = 2;

	localparam logic [31:0] SIG_MASK    = 32'hffffff00;
	localparam logic [31:0] SIG_VALUE   = 32'h564d3300;
	localparam logic [42:0] WRAP_WINDOW = 43'h1FFFFFFF;

	localparam logic CMD_HEADER  = 1'b0;
	localparam logic CMD_READOUT = 1'b1;

	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_HIT     = 2'd1;
	localparam logic [1:0] KIND_MARKER  = 2'd2;
	localparam logic [1:0] KIND_DROPPED = 2'd3;

	localparam logic [3:0] ST_OK         = 4'd0;
	localparam logic [3:0] ST_NO_MARKER  = 4'd1;
	localparam logic [3:0] ST_UNDERSIZE  = 4'd2;
	localparam logic [3:0] ST_TOO_SHORT  = 4'd3;
	localparam logic [3:0] ST_UNKNOWN_ID = 4'd4;
	localparam logic [3:0] ST_BAD_FEC    = 4'd5;
	localparam logic [3:0] ST_BAD_LENGTH = 4'd6;
	localparam logic [3:0] ST_MARKER_SEQ = 4'd7;
	localparam logic [3:0] ST_WRAP       = 4'd8;
	localparam logic [3:0] ST_DROPPED    = 4'd9;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  status;
		logic        frame_seq_error;
		logic [5:0]  lost_timestamps;
		logic        over_threshold;
		logic [5:0]  channel;
		logic [7:0]  tdc;
		logic [4:0]  vmm_id;
		logic [4:0]  trigger_offset;
		logic [9:0]  adc;
		logic [11:0] bcid;
		logic [41:0] fec_timestamp;
	} result_t;

	// one classified item waiting for the timestamp table
	typedef struct packed {
		result_t             res;
		logic                lookup;     // touches the table
		logic                is_marker;
		logic [TADDR_W-1:0]  addr;
	} entry_t;

	function automatic logic [11:0] gray_decode12(input logic [11:0] g);
		logic [11:0] b;
		b = g;
		b = b ^ (b >> 1);
		b = b ^ (b >> 2);
		b = b ^ (b >> 4);
		b = b ^ (b >> 8);
		return b;
	endfunction

	// x mod 3 == 0 : base-4 digits all weigh 1 mod 3
	function automatic logic div3(input logic [13:0] x);
		logic [4:0] s;
		logic [2:0] t;
		s = '0;
		for (int i = 0; i < 7; i++) begin
			s = s + 5'(x[2*i +: 2]);
		end
		t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
		return (t == 3'd0) || (t == 3'd3) || (t == 3'd6);
	endfunction

endpackage

// ----- design/vrp_ram.sv -----
// vrp_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module vrp_ram #(
	parameter int WIDTH = 42,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- design/vrp_front.sv -----
// vrp_front: accepts items, runs header checks and frame state, classifies readouts.
// Depends on vrp_pkg.
`timescale 1ns / 1ps
module vrp_front #(
	parameter int VMMS_PER_FEC = vrp_pkg::VMMS_PER_FEC_DEF,
	parameter int FEC_COUNT    = vrp_pkg::FEC_COUNT_DEF,
	parameter int MAX_HITS     = vrp_pkg::MAX_HITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  logic                command,
	input  logic [13:0]         frame_bytes,
	input  logic [31:0]         frame_counter,
	input  logic [31:0]         data_id,
	input  logic [31:0]         offset_overflow,
	input  logic [31:0]         readout_high,
	input  logic [15:0]         readout_low,
	input  logic                q_ready,
	input  logic                busy,
	output logic                push,
	output vrp_pkg::entry_t     push_entry
);
	localparam int FIDX_W = (FEC_COUNT > 1) ? $clog2(FEC_COUNT) : 1;
	localparam int VIDX_W = (VMMS_PER_FEC > 1) ? $clog2(VMMS_PER_FEC) : 1;
	localparam int HC_W   = $clog2(MAX_HITS + 1);
	localparam logic [31:0] VMASK = 32'((64'd1 << VMMS_PER_FEC) - 64'd1);

	logic [31:0]             exp_frame_q;
	logic [3:0]              cur_fec_q;
	logic                    accepted_q;
	logic [HC_W-1:0]         hit_cnt_q;
	logic [VMMS_PER_FEC-1:0] seen_q [FEC_COUNT];

	logic [31:0]             exp_frame_n;
	logic [3:0]              cur_fec_n;
	logic                    accepted_n;
	logic                    clear_hits, clear_seen, set_seen, count_hit;
	logic [3:0]              hdr_fec;
	logic                    hdr_fec_ok, cur_fec_ok;
	logic [FIDX_W-1:0]       hdr_idx, cur_idx;
	logic [31:0]             seen_ext, diff;
	logic [13:0]             payload;
	logic                    is_hit, drop, in_table;
	logic [4:0]              vmm;
	vrp_pkg::entry_t         e;

	assign item_ready = q_ready && !busy;
	assign push       = item_valid && item_ready;

	assign hdr_fec    = data_id[7:4];
	assign hdr_fec_ok = (hdr_fec != 4'd0) && ({1'b0, hdr_fec} <= 5'(FEC_COUNT));
	assign cur_fec_ok = (cur_fec_q != 4'd0) && ({1'b0, cur_fec_q} <= 5'(FEC_COUNT));
	assign hdr_idx    = FIDX_W'(hdr_fec - 4'd1);
	assign cur_idx    = FIDX_W'(cur_fec_q - 4'd1);
	assign seen_ext   = 32'(seen_q[hdr_idx]);
	assign diff       = (offset_overflow ^ seen_ext) & VMASK;
	assign payload    = frame_bytes - 14'(vrp_pkg::HEADER_BYTES);

	assign is_hit   = readout_low[15];
	assign vmm      = is_hit ? readout_high[26:22] : readout_low[14:10];
	assign in_table = {1'b0, vmm} < 6'(VMMS_PER_FEC);
	assign drop     = !accepted_q || !cur_fec_ok || (32'(hit_cnt_q) >= 32'(MAX_HITS));

	always_comb begin
		e           = '0;
		exp_frame_n = exp_frame_q;
		cur_fec_n   = cur_fec_q;
		accepted_n  = accepted_q;
		clear_hits  = 1'b0;
		clear_seen  = 1'b0;
		set_seen    = 1'b0;
		count_hit   = 1'b0;
		if (command == vrp_pkg::CMD_HEADER) begin
			e.res.kind = vrp_pkg::KIND_HEADER;
			accepted_n = 1'b0;
			if (frame_bytes < 14'd4) begin
				e.res.status = vrp_pkg::ST_UNDERSIZE;
			end else begin
				e.res.frame_seq_error = (frame_counter != exp_frame_q);
				exp_frame_n = frame_counter + 32'd1;
				if (frame_bytes < 14'(vrp_pkg::HEADER_BYTES + vrp_pkg::WORD_BYTES)) begin
					e.res.status = vrp_pkg::ST_TOO_SHORT;
				end else if ((data_id & vrp_pkg::SIG_MASK) != vrp_pkg::SIG_VALUE) begin
					e.res.status = vrp_pkg::ST_UNKNOWN_ID;
				end else begin
					cur_fec_n = hdr_fec;
					if (!hdr_fec_ok) begin
						e.res.status = vrp_pkg::ST_BAD_FEC;
					end else begin
						e.res.lost_timestamps = 6'($countones(diff));
						clear_seen = 1'b1;
						// multiple of 6 = even and multiple of 3
						if (payload[0] || !vrp_pkg::div3(payload)) begin
							e.res.status = vrp_pkg::ST_BAD_LENGTH;
						end else begin
							e.res.status = vrp_pkg::ST_OK;
							accepted_n = 1'b1;
							clear_hits = 1'b1;
						end
					end
				end
			end
		end else if (drop) begin
			e.res.kind   = vrp_pkg::KIND_DROPPED;
			e.res.status = vrp_pkg::ST_DROPPED;
		end else begin
			e.res.vmm_id = vmm;
			e.lookup     = in_table;
			e.addr       = vrp_pkg::TADDR_W'(32'(cur_idx) * VMMS_PER_FEC + 32'(vmm));
			if (is_hit) begin
				e.res.kind           = vrp_pkg::KIND_HIT;
				e.res.over_threshold = readout_low[14];
				e.res.channel        = readout_low[13:8];
				e.res.tdc            = readout_low[7:0];
				e.res.trigger_offset = readout_high[31:27];
				e.res.adc            = readout_high[21:12];
				e.res.bcid           = vrp_pkg::gray_decode12(readout_high[11:0]);
				count_hit            = 1'b1;
			end else begin
				e.res.kind          = vrp_pkg::KIND_MARKER;
				e.is_marker         = 1'b1;
				e.res.fec_timestamp = {readout_high, readout_low[9:0]};
				set_seen            = in_table;
			end
		end
	end

	assign push_entry = e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_frame_q <= '0;
			cur_fec_q   <= '0;
			accepted_q  <= 1'b0;
			hit_cnt_q   <= '0;
			for (int i = 0; i < FEC_COUNT; i++) begin
				seen_q[i] <= '0;
			end
		end else if (push) begin
			exp_frame_q <= exp_frame_n;
			cur_fec_q   <= cur_fec_n;
			accepted_q  <= accepted_n;
			if (clear_hits) begin
				hit_cnt_q <= '0;
			end else if (count_hit) begin
				hit_cnt_q <= hit_cnt_q + HC_W'(1);
			end
			if (clear_seen) begin
				seen_q[hdr_idx] <= '0;
			end else if (set_seen) begin
				// set_seen implies vmm is inside the table
				seen_q[cur_idx][vmm[VIDX_W-1:0]] <= 1'b1;
			end
		end
	end
endmodule

// ----- design/vrp_queue.sv -----
// vrp_queue: short FIFO of classified items between front and back.
// Depends on vrp_pkg.
`timescale 1ns / 1ps
module vrp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  vrp_pkg::entry_t push_entry,
	output logic            q_ready,
	input  logic            pop,
	output logic            q_valid,
	output vrp_pkg::entry_t q_entry
);
	localparam int PW = (vrp_pkg::QUEUE_DEPTH > 1) ? $clog2(vrp_pkg::QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(vrp_pkg::QUEUE_DEPTH + 1);

	vrp_pkg::entry_t slot_q [vrp_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;

	assign q_ready = (32'(cnt_q) < vrp_pkg::QUEUE_DEPTH);
	assign q_valid = (cnt_q != '0);
	assign q_entry = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (32'(wr_q) == vrp_pkg::QUEUE_DEPTH - 1) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (32'(rd_q) == vrp_pkg::QUEUE_DEPTH - 1) ? '0 : rd_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end
endmodule

// ----- design/vrp_back.sv -----
// vrp_back: timestamp-table lookup and update, clearing pass, result register.
// Depends on vrp_pkg and vrp_ram.
`timescale 1ns / 1ps
module vrp_back #(
	parameter int VMMS_PER_FEC = vrp_pkg::VMMS_PER_FEC_DEF,
	parameter int FEC_COUNT    = vrp_pkg::FEC_COUNT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  vrp_pkg::entry_t q_entry,
	output logic            pop,
	output logic            busy,
	output logic            result_valid,
	input  logic            result_ready,
	output vrp_pkg::result_t res
);
	localparam int DEPTH = FEC_COUNT * VMMS_PER_FEC;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	vrp_pkg::entry_t  s1_q;
	logic             s1_vld_q;
	vrp_pkg::result_t res_q;
	logic             out_vld_q;
	logic             busy_q;
	logic [AW-1:0]    clr_addr_q;
	logic             fwd_vld_q;
	logic [AW-1:0]    fwd_addr_q;
	logic [41:0]      fwd_data_q;

	logic             out_free, s1_fire, s1_load, we, ram_we;
	logic [AW-1:0]    raddr, waddr, s1_addr;
	logic [41:0]      rdata, old, t, ram_wdata;
	vrp_pkg::result_t r;

	assign out_free = !out_vld_q || result_ready;
	assign s1_fire  = s1_vld_q && out_free;
	assign s1_load  = q_valid && (!s1_vld_q || s1_fire);
	assign pop      = s1_load;
	assign s1_addr  = s1_q.addr[AW-1:0];
	// keep the read aimed at whatever sits in s1 next cycle
	assign raddr    = s1_load ? q_entry.addr[AW-1:0] : s1_addr;

	assign old = (fwd_vld_q && fwd_addr_q == s1_addr) ? fwd_data_q : rdata;
	assign t   = s1_q.lookup ? old : '0;

	always_comb begin
		r = s1_q.res;
		if (r.kind == vrp_pkg::KIND_HIT) begin
			r.status        = (t != '0) ? vrp_pkg::ST_OK : vrp_pkg::ST_NO_MARKER;
			r.fec_timestamp = t;
		end else if (r.kind == vrp_pkg::KIND_MARKER && s1_q.lookup && old > r.fec_timestamp) begin
			r.status = (({1'b0, old}) < ({1'b0, r.fec_timestamp} + vrp_pkg::WRAP_WINDOW))
				? vrp_pkg::ST_MARKER_SEQ : vrp_pkg::ST_WRAP;
		end
	end

	assign we        = s1_fire && s1_q.is_marker && s1_q.lookup;
	assign ram_we    = busy_q || we;
	assign waddr     = busy_q ? clr_addr_q : s1_addr;
	assign ram_wdata = busy_q ? '0 : s1_q.res.fec_timestamp;

	vrp_ram #(.WIDTH(42), .DEPTH(DEPTH)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (ram_wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (s1_load) begin
			s1_q <= q_entry;
		end
		if (s1_fire) begin
			res_q <= r;
		end
		fwd_addr_q <= s1_addr;
		fwd_data_q <= s1_q.res.fec_timestamp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q   <= 1'b0;
			out_vld_q  <= 1'b0;
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
			fwd_vld_q  <= 1'b0;
		end else begin
			fwd_vld_q <= we;
			if (s1_load) begin
				s1_vld_q <= 1'b1;
			end else if (s1_fire) begin
				s1_vld_q <= 1'b0;
			end
			if (s1_fire) begin
				out_vld_q <= 1'b1;
			end else if (result_ready) begin
				out_vld_q <= 1'b0;
			end
			if (busy_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (32'(clr_addr_q) == DEPTH - 1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign busy         = busy_q;
	assign result_valid = out_vld_q;
	assign res          = res_q;
endmodule

// ----- design/vmm3_readout_parser.sv -----
// vmm3_readout_parser: top level of the VMM3 readout-frame parser.
// Depends on vrp_pkg, vrp_front, vrp_queue, vrp_back (and vrp_ram below it).
//
//   channel   handshake                    payload
//   input     item_valid / item_ready      command .. readout_low
//   output    result_valid / result_ready  kind .. fec_timestamp
//
// One request per cycle sustained while result_ready stays high; a taken request
// passes a queue slot, then s1 with the table read, then the result register.
// Per-VMM marker times live in one RAM with registered read; a marker write is
// forwarded to the next request that reads the same entry.
// After reset a clearing pass zeroes all FEC_COUNT*VMMS_PER_FEC table entries
// (512 by default), with item_ready held low.
// An output stall backs up through the two-entry queue to item_ready.
`timescale 1ns / 1ps
module vmm3_readout_parser #(
	parameter int VMMS_PER_FEC = vrp_pkg::VMMS_PER_FEC_DEF,
	parameter int FEC_COUNT    = vrp_pkg::FEC_COUNT_DEF,
	parameter int MAX_HITS     = vrp_pkg::MAX_HITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        command,
	input  logic [13:0] frame_bytes,
	input  logic [31:0] frame_counter,
	input  logic [31:0] data_id,
	input  logic [31:0] offset_overflow,
	input  logic [31:0] readout_high,
	input  logic [15:0] readout_low,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  kind,
	output logic [3:0]  status,
	output logic        frame_seq_error,
	output logic [5:0]  lost_timestamps,
	output logic        over_threshold,
	output logic [5:0]  channel,
	output logic [7:0]  tdc,
	output logic [4:0]  vmm_id,
	output logic [4:0]  trigger_offset,
	output logic [9:0]  adc,
	output logic [11:0] bcid,
	output logic [41:0] fec_timestamp
);
	logic             push, pop, q_ready, q_valid, busy;
	vrp_pkg::entry_t  push_entry, q_entry;
	vrp_pkg::result_t res;

	// front: header checks, frame state, marker-seen flags
	vrp_front #(
		.VMMS_PER_FEC (VMMS_PER_FEC),
		.FEC_COUNT    (FEC_COUNT),
		.MAX_HITS     (MAX_HITS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_ready      (item_ready),
		.command         (command),
		.frame_bytes     (frame_bytes),
		.frame_counter   (frame_counter),
		.data_id         (data_id),
		.offset_overflow (offset_overflow),
		.readout_high    (readout_high),
		.readout_low     (readout_low),
		.q_ready         (q_ready),
		.busy            (busy),
		.push            (push),
		.push_entry      (push_entry)
	);

	vrp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.q_ready    (q_ready),
		.pop        (pop),
		.q_valid    (q_valid),
		.q_entry    (q_entry)
	);

	// back: marker-time table, status of hits and markers
	vrp_back #(
		.VMMS_PER_FEC (VMMS_PER_FEC),
		.FEC_COUNT    (FEC_COUNT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_entry      (q_entry),
		.pop          (pop),
		.busy         (busy),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.res          (res)
	);

	assign kind            = res.kind;
	assign status          = res.status;
	assign frame_seq_error = res.frame_seq_error;
	assign lost_timestamps = res.lost_timestamps;
	assign over_threshold  = res.over_threshold;
	assign channel         = res.channel;
	assign tdc             = res.tdc;
	assign vmm_id          = res.vmm_id;
	assign trigger_offset  = res.trigger_offset;
	assign adc             = res.adc;
	assign bcid            = res.bcid;
	assign fec_timestamp   = res.fec_timestamp;
endmodule

// ----- dv/tb_top.sv -----
// tb_top: self-checking bench for vmm3_readout_parser.
// Depends on vrp_pkg (codes, result_t) and the design under design/.
// Drives directed then random header/readout requests, predicts every result.
`timescale 1ns / 1ps
module tb_top;
	import vrp_pkg::*;

	localparam int FECS  = 16;
	localparam int VMMS  = 32;
	localparam int HITS  = 512;
	localparam int N_RAND = 2000;

	typedef struct {
		logic        cmd;
		logic [13:0] bytes;
		logic [31:0] fc;
		logic [31:0] did;
		logic [31:0] mask;
		logic [31:0] hi;
		logic [15:0] lo;
	} request_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #6 clk = ~clk;

	logic        item_valid = 1'b0;
	logic        item_ready;
	logic        command = 1'b0;
	logic [13:0] frame_bytes = '0;
	logic [31:0] frame_counter = '0;
	logic [31:0] data_id = '0;
	logic [31:0] offset_overflow = '0;
	logic [31:0] readout_high = '0;
	logic [15:0] readout_low = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [1:0]  kind;
	logic [3:0]  status;
	logic        frame_seq_error;
	logic [5:0]  lost_timestamps;
	logic        over_threshold;
	logic [5:0]  channel;
	logic [7:0]  tdc;
	logic [4:0]  vmm_id;
	logic [4:0]  trigger_offset;
	logic [9:0]  adc;
	logic [11:0] bcid;
	logic [41:0] fec_timestamp;

	vmm3_readout_parser DUT (.*);

	// ---------------- parser state mirror ----------------
	logic [41:0] ts_table [FECS*VMMS];
	logic [31:0] seen_flags [FECS];
	logic [31:0] next_frame;
	logic [3:0]  fec_sel;
	logic        frame_ok;
	int          hits_taken;

	request_t    pending[$];
	result_t     expected[$];
	int          errors = 0;
	int          n_results = 0;
	int          n_hits = 0, n_markers = 0, n_drops = 0, n_headers = 0;
	int          gap_left = 0;

	function automatic logic [11:0] bcid_from_gray(logic [11:0] g);
		logic [11:0] b;
		b[11] = g[11];
		for (int i = 10; i >= 0; i--) b[i] = b[i+1] ^ g[i];
		return b;
	endfunction

	function automatic result_t parse_request(request_t r);
		result_t     o;
		logic [41:0] stored, ts;
		logic [4:0]  v;
		int          idx;
		o = '0;
		if (r.cmd == CMD_HEADER) begin
			o.kind = KIND_HEADER;
			frame_ok = 1'b0;
			if (r.bytes < 4) begin
				o.status = ST_UNDERSIZE;
				return o;
			end
			o.frame_seq_error = (r.fc != next_frame);
			next_frame = r.fc + 32'd1;
			if (r.bytes < HEADER_BYTES + WORD_BYTES) begin
				o.status = ST_TOO_SHORT;
				return o;
			end
			if ((r.did & SIG_MASK) != SIG_VALUE) begin
				o.status = ST_UNKNOWN_ID;
				return o;
			end
			fec_sel = r.did[7:4];
			if (fec_sel == 0) begin
				o.status = ST_BAD_FEC;
				return o;
			end
			o.lost_timestamps = 6'($countones(r.mask ^ seen_flags[fec_sel-1]));
			seen_flags[fec_sel-1] = '0;
			if ((r.bytes - HEADER_BYTES) % WORD_BYTES != 0) begin
				o.status = ST_BAD_LENGTH;
				return o;
			end
			frame_ok = 1'b1;
			hits_taken = 0;
			o.status = ST_OK;
			return o;
		end
		// readout word
		if (!frame_ok || fec_sel == 0 || hits_taken >= HITS) begin
			o.kind = KIND_DROPPED;
			o.status = ST_DROPPED;
			return o;
		end
		if (r.lo[15]) begin
			v = r.hi[26:22];
			idx = (fec_sel - 1) * VMMS + v;
			stored = ts_table[idx];
			o.kind = KIND_HIT;
			o.status = (stored != 0) ? ST_OK : ST_NO_MARKER;
			o.over_threshold = r.lo[14];
			o.channel = r.lo[13:8];
			o.tdc = r.lo[7:0];
			o.vmm_id = v;
			o.trigger_offset = r.hi[31:27];
			o.adc = r.hi[21:12];
			o.bcid = bcid_from_gray(r.hi[11:0]);
			o.fec_timestamp = stored;
			hits_taken++;
		end else begin
			v = r.lo[14:10];
			idx = (fec_sel - 1) * VMMS + v;
			ts = {r.hi, r.lo[9:0]};
			o.kind = KIND_MARKER;
			o.status = ST_OK;
			o.vmm_id = v;
			o.fec_timestamp = ts;
			stored = ts_table[idx];
			// later time stored: near means out of order, far means wrap
			if (stored > ts)
				o.status = ({1'b0, stored} < {1'b0, ts} + 43'(WRAP_WINDOW)) ?
					ST_MARKER_SEQ : ST_WRAP;
			ts_table[idx] = ts;
			seen_flags[fec_sel-1][v] = 1'b1;
		end
		return o;
	endfunction

	// ---------------- request generation ----------------
	logic [31:0] gen_seq = '0;
	logic [41:0] gen_time [FECS*VMMS];

	task automatic push_header(int bytes, logic [31:0] fc, logic [31:0] did, logic [31:0] mask);
		request_t r;
		r = '{CMD_HEADER, 14'(bytes), fc, did, mask, $urandom, 16'($urandom)};
		pending.push_back(r);
		if (bytes >= 4) gen_seq = fc + 1;
	endtask

	task automatic push_readout(logic [31:0] hi, logic [15:0] lo);
		request_t r;
		r = '{CMD_READOUT, 14'($urandom), $urandom, $urandom, $urandom, hi, lo};
		pending.push_back(r);
	endtask

	task automatic push_marker(int fec, logic [4:0] v, bit in_order);
		logic [41:0] t;
		int idx;
		idx = (fec - 1) * VMMS + v;
		if (in_order) t = gen_time[idx] + 42'($urandom_range(1, 100000));
		else t = {$urandom, 10'($urandom)};
		gen_time[idx] = t;
		push_readout(t[41:10], {1'b0, v, t[9:0]});
	endtask

	task automatic push_hit(logic [4:0] v);
		logic [31:0] hi;
		hi = $urandom;
		hi[26:22] = v;
		push_readout(hi, {1'b1, 15'($urandom)});
	endtask

	task automatic push_frame(int fec, int words);
		push_header(HEADER_BYTES + WORD_BYTES * words, gen_seq,
			SIG_VALUE | (32'(fec) << 4) | 32'($urandom_range(0, 15)), $urandom);
		for (int i = 0; i < words; i++) begin
			if ($urandom_range(0, 9) < 6) push_hit(5'($urandom));
			else push_marker(fec, 5'($urandom), $urandom_range(0, 15) != 0);
		end
	endtask

	// ---------------- driver ----------------
	always @(posedge clk or negedge arst_n) begin
		request_t r;
		if (!arst_n) begin
			item_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (item_valid && item_ready) begin
				r = '{command, frame_bytes, frame_counter, data_id, offset_overflow,
					readout_high, readout_low};
				expected.push_back(parse_request(r));
			end
			if (!item_valid || item_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					item_valid <= 1'b0;
				end else if (pending.size() > 0) begin
					r = pending.pop_front();
					command <= r.cmd;
					frame_bytes <= r.bytes;
					frame_counter <= r.fc;
					data_id <= r.did;
					offset_overflow <= r.mask;
					readout_high <= r.hi;
					readout_low <= r.lo;
					item_valid <= 1'b1;
					// sender gaps only outside the tail of the run
					if (pending.size() > 200 && $urandom_range(0, 7) == 0)
						gap_left <= $urandom_range(1, 7);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- receiver ----------------
	int  stall_left = 0;
	int  hold_left = 0;
	bit  held_once = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_ready <= 1'b0;
		end else if (!held_once && n_results >= 400) begin
			// long back-pressure: queue fills, item_ready must drop
			held_once <= 1;
			hold_left <= 150;
			result_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			result_ready <= 1'b0;
		end else if (pending.size() > 200 && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 6);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	// ---------------- monitor ----------------
	task automatic report(string field, logic [41:0] got, logic [41:0] want);
		if (got !== want) begin
			errors++;
			$display("mismatch result %0d %s: got %h want %h", n_results, field, got, want);
		end
	endtask

	always @(posedge clk) begin
		result_t w;
		if (arst_n && result_valid && result_ready) begin
			if (expected.size() == 0) begin
				errors++;
				$display("unexpected result %0d kind %0d", n_results, kind);
			end else begin
				w = expected.pop_front();
				report("kind", kind, w.kind);
				report("status", status, w.status);
				report("frame_seq_error", frame_seq_error, w.frame_seq_error);
				report("lost_timestamps", lost_timestamps, w.lost_timestamps);
				report("over_threshold", over_threshold, w.over_threshold);
				report("channel", channel, w.channel);
				report("tdc", tdc, w.tdc);
				report("vmm_id", vmm_id, w.vmm_id);
				report("trigger_offset", trigger_offset, w.trigger_offset);
				report("adc", adc, w.adc);
				report("bcid", bcid, w.bcid);
				report("fec_timestamp", fec_timestamp, w.fec_timestamp);
				case (w.kind)
					KIND_HEADER: n_headers++;
					KIND_HIT: n_hits++;
					KIND_MARKER: n_markers++;
					default: n_drops++;
				endcase
			end
			n_results++;
		end
	end

	// ---------------- stimulus and end of run ----------------
	initial begin
		int pick, fec;
		for (int i = 0; i < FECS*VMMS; i++) begin
			ts_table[i] = '0;
			gen_time[i] = '0;
		end
		for (int i = 0; i < FECS; i++) seen_flags[i] = '0;
		next_frame = '0;
		fec_sel = '0;
		frame_ok = 1'b0;
		hits_taken = 0;

		// directed: drops after reset, each header check, marker order cases
		push_readout(32'hffffffff, 16'hffff);               // readout before any header
		push_header(3, 32'h1234, SIG_VALUE | 32'h10, '0);    // undersize, counter untouched
		push_header(21, 32'h0, SIG_VALUE | 32'h10, '0);      // too short
		push_header(22, 32'h5, 32'hdeadbe10, '0);            // unknown id, sequence error
		push_header(22, gen_seq, SIG_VALUE | 32'h0f, '0);    // front end zero
		push_header(23, gen_seq, SIG_VALUE | 32'h10, '1);    // bad length
		push_readout(32'h0, 16'h8000);                       // dropped after rejected frame
		push_header(52, gen_seq, SIG_VALUE | 32'h10, 32'h0); // accepted, front end 1
		push_hit(5'd0);                                      // hit with no marker yet
		push_readout(32'h0000_1000, {1'b0, 5'd0, 10'h3ff});  // marker vmm 0
		push_hit(5'd0);
		push_readout(32'h0000_0800, {1'b0, 5'd0, 10'h000});  // small step back: sequence error
		push_readout(32'hffff_ffff, {1'b0, 5'd0, 10'h3ff});  // max time
		push_readout(32'h0, {1'b0, 5'd0, 10'h001});          // far back: wrap
		push_readout(32'h0, {1'b0, 5'd31, 10'h000});         // vmm 31, time zero
		push_readout(32'hffff_ffff, 16'hffff);               // hit, all fields at max
		push_readout(32'hffff_ffff, 16'h0000);
		push_header(8998, 32'hffff_ffff, SIG_VALUE | 32'hf0, 32'h8000_0001);
		push_header(22, 32'h0, SIG_VALUE | 32'hf0, 32'hffff_ffff); // counter wraps to zero
		push_hit(5'd31);

		// hit limit: one frame of hits only, longer than the limit, then a marker
		push_header(HEADER_BYTES + WORD_BYTES * (HITS + 12), gen_seq, SIG_VALUE | 32'h70,
			$urandom);
		for (int i = 0; i < HITS + 11; i++) push_hit(5'($urandom));
		push_marker(7, 5'd3, 1'b1);

		while (pending.size() < N_RAND) begin
			pick = $urandom_range(0, 99);
			fec = $urandom_range(1, 15);
			if (pick < 85) begin
				push_frame(fec, $urandom_range(1, 20));
			end else if (pick < 92) begin
				// broken or random header
				push_header($urandom_range(0, 9000),
					($urandom_range(0, 1) != 0) ? gen_seq : $urandom,
					($urandom_range(0, 1) != 0) ? (SIG_VALUE | 32'($urandom_range(0, 255))) : $urandom,
					$urandom);
			end else begin
				push_readout($urandom, 16'($urandom));
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending.size() == 0 && !item_valid);
		wait (expected.size() == 0);
		repeat (20) @(posedge clk);
		$display("run covered %0d results: %0d headers, %0d hits, %0d markers, %0d dropped",
			n_results, n_headers, n_hits, n_markers, n_drops);
		$display("receiver long hold-off exercised: %0d", held_once);
		if (errors == 0 && expected.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d results outstanding", expected.size());
		$display("FAILURE");
		$finish;
	end

endmodule

// ----- vmm3_readout_parser.f -----
design/vrp_pkg.sv
design/vrp_ram.sv
design/vrp_front.sv
design/vrp_queue.sv
design/vrp_back.sv
design/vmm3_readout_parser.sv
dv/tb_top.sv
